// ----- design/tlmq_pkg.sv -----
// Shared types and constants for the timed LCD message queue.
`timescale 1ns / 1ps
package tlmq_pkg;

    localparam int SCREENS    = 2;
    localparam int SLOT_IDX_W = 4;
    localparam int LEN_W      = 6;
    localparam int QDEPTH     = 2;

    localparam logic [7:0] LCD_CLEAR   = 8'h01;
    localparam logic [7:0] CURSOR_ROW0 = 8'h80;
    localparam logic [7:0] CURSOR_ROW1 = 8'hB8;
    localparam logic [7:0] ROW_SPLIT   = 8'd17;
    localparam logic [7:0] ROW1_OFFSET = 8'd9;
    localparam logic [7:0] HOLD_START  = 8'd2;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_WRITE = 3'd1,
        CMD_ERROR = 3'd2,
        CMD_CLEAR = 3'd3,
        CMD_ON    = 3'd4,
        CMD_OFF   = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_READ = 2'd1,
        PH_HOLD = 2'd2,
        PH_DROP = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        B_IDLE  = 2'd0,
        B_PRIME = 2'd1,
        B_RUN   = 2'd2
    } back_state_t;

    typedef struct packed {
        logic                  is_read;
        logic                  scr;
        logic                  drop;
        logic [SLOT_IDX_W-1:0] slot;
        logic [LEN_W-1:0]      len;
    } job_t;

    typedef struct packed {
        logic                  en;
        logic                  scr;
        logic [SLOT_IDX_W-1:0] slot;
        logic [LEN_W-1:0]      pos;
        logic [7:0]            data;
    } text_wr_t;

endpackage

// ----- design/timed_lcd_message_queue.sv -----
// Top level of the timed LCD message queue: front, job queue and back.
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | command screen_sel char_byte end_of_message timeout
//  out     | out_valid | out_stall | lcd_screen entry_kind cursor_command char_code
//          |           |           | drop_event last_of_run
//
// Non-character items pass through the front unless the job queue is full;
// character items wait until the back has drained its jobs, since they write the
// text memory the back reads.
// A read job first primes the text memory, then gives one result per cycle while
// out_stall allows: a clear plus up to SLOT_BYTES-1 characters, paced by the single read port.
// Other jobs give a single result. out_stall holds the back whenever its
// output register is full. Reset clears all control state; no clearing pass.
`timescale 1ns / 1ps
module timed_lcd_message_queue
    import tlmq_pkg::*;
#(
    parameter int SLOTS      = 4,
    parameter int SLOT_BYTES = 33
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] command,
    input  logic       screen_sel,
    input  logic [7:0] char_byte,
    input  logic       end_of_message,
    input  logic [7:0] timeout,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       lcd_screen,
    output logic       entry_kind,
    output logic [7:0] cursor_command,
    output logic [7:0] char_code,
    output logic       drop_event,
    output logic       last_of_run
);

    logic     accept;
    logic     job_valid;
    job_t     job;
    job_t     head;
    text_wr_t text_wr;
    logic     empty;
    logic     full;
    logic     pop;
    logic     busy;
    logic     is_char;

    assign is_char  = (command == CMD_WRITE) || (command == CMD_ERROR);
    assign in_stall = full || (is_char && (!empty || busy));
    assign accept   = in_valid && !in_stall;

    tlmq_front #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .command        (command),
        .screen_sel     (screen_sel),
        .char_byte      (char_byte),
        .end_of_message (end_of_message),
        .timeout        (timeout),
        .job_valid      (job_valid),
        .job            (job),
        .text_wr        (text_wr)
    );

    tlmq_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_valid),
        .push_job (job),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    tlmq_back #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .text_wr        (text_wr),
        .head           (head),
        .empty          (empty),
        .pop            (pop),
        .busy           (busy),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .lcd_screen     (lcd_screen),
        .entry_kind     (entry_kind),
        .cursor_command (cursor_command),
        .char_code      (char_code),
        .drop_event     (drop_event),
        .last_of_run    (last_of_run)
    );

endmodule

// ----- design/tlmq_fifo.sv -----
// Two-entry job queue between the front and back parts.
`timescale 1ns / 1ps
module tlmq_fifo
    import tlmq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    localparam int PW = $clog2(QDEPTH);

    job_t          mem_reg [QDEPTH];
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] rp_reg;
    logic [PW:0]   cnt_reg;

    assign head  = mem_reg[rp_reg];
    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (PW+1)'(QDEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == PW'(QDEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == PW'(QDEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ----- design/tlmq_front.sv -----
// Front part: accepts items, keeps per-screen queue state, issues jobs and text writes.
`timescale 1ns / 1ps
module tlmq_front
    import tlmq_pkg::*;
#(
    parameter int SLOTS      = 4,
    parameter int SLOT_BYTES = 33
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [2:0] command,
    input  logic       screen_sel,
    input  logic [7:0] char_byte,
    input  logic       end_of_message,
    input  logic [7:0] timeout,
    output logic       job_valid,
    output job_t       job,
    output text_wr_t   text_wr
);

    localparam int SW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOT_BYTES);
    localparam int CW = $clog2(SLOTS + 1);

    logic             cs_reg, cs_next;
    logic [SLOTS-1:0] occ_reg  [SCREENS];
    logic [SLOTS-1:0] occ_next [SCREENS];
    logic [7:0]       dur_reg  [SCREENS][SLOTS];
    logic [7:0]       dur_next [SCREENS][SLOTS];
    logic [LW-1:0]    len_reg  [SCREENS][SLOTS];
    logic [LW-1:0]    len_next [SCREENS][SLOTS];
    logic             en_reg   [SCREENS];
    logic             en_next  [SCREENS];
    logic             lock_reg [SCREENS];
    logic             lock_next[SCREENS];
    logic [SW-1:0]    wr_reg   [SCREENS];
    logic [SW-1:0]    wr_next  [SCREENS];
    logic [SW-1:0]    rd_reg   [SCREENS];
    logic [SW-1:0]    rd_next  [SCREENS];
    logic [SW-1:0]    shown_reg[SCREENS];
    logic [SW-1:0]    shown_next[SCREENS];
    logic [CW-1:0]    cnt_reg  [SCREENS];
    logic [CW-1:0]    cnt_next [SCREENS];
    phase_t           ph_reg   [SCREENS];
    phase_t           ph_next  [SCREENS];
    logic [7:0]       ht_reg   [SCREENS];
    logic [7:0]       ht_next  [SCREENS];
    logic [LW-1:0]    fp_reg   [SCREENS];
    logic [LW-1:0]    fp_next  [SCREENS];
    logic             fa_reg   [SCREENS];
    logic             fa_next  [SCREENS];
    logic             disc_reg [SCREENS];
    logic             disc_next[SCREENS];

    always_comb
    begin
        logic          s;
        logic          flush;
        logic          done;
        logic          found;
        logic [SW:0]   sum;
        logic [SW-1:0] idx;
        logic [SW-1:0] p;
        logic [SW-1:0] d;
        logic [SW-1:0] r;
        logic [SW-1:0] w;
        cs_next    = cs_reg;
        occ_next   = occ_reg;
        dur_next   = dur_reg;
        len_next   = len_reg;
        en_next    = en_reg;
        lock_next  = lock_reg;
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        shown_next = shown_reg;
        cnt_next   = cnt_reg;
        ph_next    = ph_reg;
        ht_next    = ht_reg;
        fp_next    = fp_reg;
        fa_next    = fa_reg;
        disc_next  = disc_reg;
        job_valid  = 1'b0;
        job        = '0;
        text_wr    = '0;
        flush      = 1'b0;
        done       = 1'b0;
        found      = 1'b0;
        p          = '0;
        sum        = '0;
        idx        = '0;
        d          = '0;
        r          = '0;
        w          = '0;
        s          = screen_sel;

        if (accept)
        begin
            flush = (command == CMD_CLEAR) || (command == CMD_OFF)
                 || ((command == CMD_ERROR) && !fa_reg[s]);
            if (command == CMD_OFF)
            begin
                lock_next[s] = 1'b0;
            end
            if (flush)
            begin
                occ_next[s] = '0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    dur_next[s][i] = '0;
                end
                rd_next[s]  = SW'(SLOTS - 1);
                wr_next[s]  = SW'(SLOTS - 1);
                cnt_next[s] = '0;
                if (fa_reg[s])
                begin
                    disc_next[s] = 1'b1;
                end
                if (!lock_next[s])
                begin
                    job_valid = 1'b1;
                    job.scr   = s;
                end
            end

            case (command)
                CMD_TICK:
                begin
                    cs_next = ~cs_reg;
                    s       = cs_next;
                    if (en_reg[s])
                    begin
                        d = shown_reg[s];
                        case (ph_reg[s])
                            PH_WAIT:
                            begin
                                if (cnt_reg[s] != '0)
                                begin
                                    ph_next[s] = PH_READ;
                                end
                            end
                            PH_READ:
                            begin
                                ph_next[s] = PH_HOLD;
                            end
                            PH_HOLD:
                            begin
                                if (occ_reg[s][d] && (dur_reg[s][d] == '0))
                                begin
                                    done = 1'b1;
                                end
                                else
                                begin
                                    if (cnt_reg[s] == '0)
                                    begin
                                        ph_next[s] = PH_WAIT;
                                    end
                                    else if (dur_reg[s][d] <= ht_reg[s])
                                    begin
                                        ph_next[s] = PH_DROP;
                                    end
                                    ht_next[s] = ht_reg[s] + 8'd1;
                                end
                            end
                            default:
                            begin
                                ph_next[s] = (cnt_reg[s] == '0) ? PH_WAIT : PH_READ;
                            end
                        endcase
                        if (!done && (ph_next[s] == PH_READ))
                        begin
                            for (int k = SLOTS; k >= 1; k--)
                            begin
                                sum = (SW+1)'(rd_reg[s]) + (SW+1)'(k);
                                if (sum >= (SW+1)'(SLOTS))
                                begin
                                    sum = sum - (SW+1)'(SLOTS);
                                end
                                idx = sum[SW-1:0];
                                if (occ_reg[s][idx])
                                begin
                                    found = 1'b1;
                                    p     = idx;
                                end
                            end
                            if (found)
                            begin
                                rd_next[s]    = p;
                                shown_next[s] = p;
                                job_valid     = 1'b1;
                                job.is_read   = 1'b1;
                                job.scr       = s;
                                job.slot      = SLOT_IDX_W'(p);
                                job.len       = LEN_W'(len_reg[s][p]);
                            end
                        end
                        else if (!done && (ph_next[s] == PH_DROP))
                        begin
                            r = rd_reg[s];
                            if (lock_reg[s])
                            begin
                                lock_next[s] = 1'b0;
                                en_next[s]   = 1'b0;
                                ph_next[s]   = PH_WAIT;
                            end
                            if (occ_reg[s][r])
                            begin
                                occ_next[s][r] = 1'b0;
                                cnt_next[s]    = cnt_reg[s] - 1'b1;
                            end
                            dur_next[s][d] = '0;
                            ht_next[s]     = HOLD_START;
                            job_valid      = 1'b1;
                            job.scr        = s;
                            job.drop       = 1'b1;
                        end
                    end
                end
                CMD_WRITE, CMD_ERROR:
                begin
                    if (!fa_reg[s])
                    begin
                        if (command == CMD_ERROR)
                        begin
                            en_next[s]   = 1'b1;
                            lock_next[s] = 1'b1;
                            ph_next[s]   = PH_WAIT;
                        end
                        for (int k = SLOTS; k >= 1; k--)
                        begin
                            sum = (SW+1)'(wr_next[s]) + (SW+1)'(k);
                            if (sum >= (SW+1)'(SLOTS))
                            begin
                                sum = sum - (SW+1)'(SLOTS);
                            end
                            idx = sum[SW-1:0];
                            if (!occ_next[s][idx])
                            begin
                                found = 1'b1;
                                p     = idx;
                            end
                        end
                        fa_next[s] = 1'b1;
                        if (found)
                        begin
                            wr_next[s]     = p;
                            dur_next[s][p] = timeout;
                            fp_next[s]     = '0;
                            disc_next[s]   = 1'b0;
                        end
                        else
                        begin
                            disc_next[s] = 1'b1;
                        end
                    end
                    if (!disc_next[s])
                    begin
                        w = wr_next[s];
                        if ((LW+1)'(fp_next[s]) < (LW+1)'(SLOT_BYTES - 1))
                        begin
                            text_wr.en   = 1'b1;
                            text_wr.scr  = s;
                            text_wr.slot = SLOT_IDX_W'(w);
                            text_wr.pos  = LEN_W'(fp_next[s]);
                            text_wr.data = char_byte;
                            fp_next[s]   = fp_next[s] + 1'b1;
                        end
                        if (end_of_message)
                        begin
                            len_next[s][w] = fp_next[s];
                            occ_next[s][w] = 1'b1;
                            cnt_next[s]    = cnt_next[s] + 1'b1;
                        end
                    end
                    if (end_of_message)
                    begin
                        fa_next[s]   = 1'b0;
                        fp_next[s]   = '0;
                        disc_next[s] = 1'b0;
                    end
                end
                CMD_ON:
                begin
                    en_next[s] = 1'b1;
                end
                CMD_OFF:
                begin
                    en_next[s] = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg <= 1'b0;
            for (int i = 0; i < SCREENS; i++)
            begin
                occ_reg[i]   <= '0;
                en_reg[i]    <= 1'b1;
                lock_reg[i]  <= 1'b0;
                wr_reg[i]    <= SW'(SLOTS - 1);
                rd_reg[i]    <= SW'(SLOTS - 1);
                shown_reg[i] <= '0;
                cnt_reg[i]   <= '0;
                ph_reg[i]    <= PH_WAIT;
                ht_reg[i]    <= HOLD_START;
                fp_reg[i]    <= '0;
                fa_reg[i]    <= 1'b0;
                disc_reg[i]  <= 1'b0;
                for (int j = 0; j < SLOTS; j++)
                begin
                    dur_reg[i][j] <= '0;
                    len_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            cs_reg     <= cs_next;
            occ_reg    <= occ_next;
            dur_reg    <= dur_next;
            len_reg    <= len_next;
            en_reg     <= en_next;
            lock_reg   <= lock_next;
            wr_reg     <= wr_next;
            rd_reg     <= rd_next;
            shown_reg  <= shown_next;
            cnt_reg    <= cnt_next;
            ph_reg     <= ph_next;
            ht_reg     <= ht_next;
            fp_reg     <= fp_next;
            fa_reg     <= fa_next;
            disc_reg   <= disc_next;
        end
    end

endmodule

// ----- design/tlmq_back.sv -----
// Back part: holds message text and plays jobs out as LCD result items.
`timescale 1ns / 1ps
module tlmq_back
    import tlmq_pkg::*;
#(
    parameter int SLOTS      = 4,
    parameter int SLOT_BYTES = 33
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  text_wr_t   text_wr,
    input  job_t       head,
    input  logic       empty,
    output logic       pop,
    output logic       busy,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       lcd_screen,
    output logic       entry_kind,
    output logic [7:0] cursor_command,
    output logic [7:0] char_code,
    output logic       drop_event,
    output logic       last_of_run
);

    localparam int SW    = $clog2(SLOTS);
    localparam int LW    = $clog2(SLOT_BYTES);
    localparam int AW    = 1 + SW + LW;
    localparam int DEPTH = 2 ** AW;

    logic [7:0]    text_mem [DEPTH];
    logic [7:0]    q_reg;

    back_state_t   st_reg, st_next;
    logic          scr_reg, scr_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic [7:0]    cur_reg, cur_next;

    logic          ov_reg, ov_next;
    logic          o_scr_reg, o_scr_next;
    logic          o_kind_reg, o_kind_next;
    logic [7:0]    o_cmd_reg, o_cmd_next;
    logic [7:0]    o_chr_reg, o_chr_next;
    logic          o_drop_reg, o_drop_next;
    logic          o_last_reg, o_last_next;

    logic          out_free;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          prime_last;
    logic          run_last;
    logic [7:0]    col;

    assign out_free   = !ov_reg || !out_stall;
    assign busy       = (st_reg != B_IDLE);
    assign prime_last = (len_reg == '0) || (q_reg == '0);
    assign run_last   = (((LW+1)'(pos_reg) + 1'b1) >= (LW+1)'(len_reg)) || (q_reg == '0);
    assign col        = 8'(pos_reg) + 8'd1;

    always_ff @(posedge clk)
    begin
        if (text_wr.en)
        begin
            text_mem[{text_wr.scr, text_wr.slot[SW-1:0], text_wr.pos[LW-1:0]}] <= text_wr.data;
        end
        if (rd_en)
        begin
            q_reg <= text_mem[rd_addr];
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            B_IDLE:
            begin
                if (!empty && head.is_read)
                begin
                    st_next = B_PRIME;
                end
            end
            B_PRIME:
            begin
                if (out_free)
                begin
                    st_next = prime_last ? B_IDLE : B_RUN;
                end
            end
            B_RUN:
            begin
                if (out_free && run_last)
                begin
                    st_next = B_IDLE;
                end
            end
            default:
            begin
                st_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop         = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = {scr_reg, slot_reg, LW'(pos_reg + 2'd2)};
        scr_next    = scr_reg;
        slot_next   = slot_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        cur_next    = cur_reg;
        ov_next     = ov_reg && out_stall;
        o_scr_next  = o_scr_reg;
        o_kind_next = o_kind_reg;
        o_cmd_next  = o_cmd_reg;
        o_chr_next  = o_chr_reg;
        o_drop_next = o_drop_reg;
        o_last_next = o_last_reg;
        case (st_reg)
            B_IDLE:
            begin
                if (!empty && (head.is_read || out_free))
                begin
                    pop = 1'b1;
                    if (head.is_read)
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = {head.scr, head.slot[SW-1:0], LW'(0)};
                        scr_next  = head.scr;
                        slot_next = head.slot[SW-1:0];
                        len_next  = head.len[LW-1:0];
                    end
                    else
                    begin
                        ov_next     = 1'b1;
                        o_scr_next  = head.scr;
                        o_kind_next = 1'b0;
                        o_cmd_next  = LCD_CLEAR;
                        o_chr_next  = '0;
                        o_drop_next = head.drop;
                        o_last_next = 1'b1;
                    end
                end
            end
            B_PRIME:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    o_scr_next  = scr_reg;
                    o_kind_next = 1'b0;
                    o_cmd_next  = LCD_CLEAR;
                    o_chr_next  = '0;
                    o_drop_next = 1'b0;
                    o_last_next = prime_last;
                    if (!prime_last)
                    begin
                        cur_next = q_reg;
                        pos_next = '0;
                        rd_en    = 1'b1;
                        rd_addr  = {scr_reg, slot_reg, LW'(1)};
                    end
                end
            end
            B_RUN:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    o_scr_next  = scr_reg;
                    o_kind_next = 1'b1;
                    o_cmd_next  = (col < ROW_SPLIT) ? (CURSOR_ROW0 + col - 8'd1)
                                                    : (CURSOR_ROW1 + col - ROW1_OFFSET);
                    o_chr_next  = cur_reg;
                    o_drop_next = 1'b0;
                    o_last_next = run_last;
                    if (!run_last)
                    begin
                        cur_next = q_reg;
                        pos_next = pos_reg + 1'b1;
                        rd_en    = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= B_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scr_reg    <= scr_next;
        slot_reg   <= slot_next;
        len_reg    <= len_next;
        pos_reg    <= pos_next;
        cur_reg    <= cur_next;
        o_scr_reg  <= o_scr_next;
        o_kind_reg <= o_kind_next;
        o_cmd_reg  <= o_cmd_next;
        o_chr_reg  <= o_chr_next;
        o_drop_reg <= o_drop_next;
        o_last_reg <= o_last_next;
    end

    assign out_valid      = ov_reg;
    assign lcd_screen     = o_scr_reg;
    assign entry_kind     = o_kind_reg;
    assign cursor_command = o_cmd_reg;
    assign char_code      = o_chr_reg;
    assign drop_event     = o_drop_reg;
    assign last_of_run    = o_last_reg;

`ifndef SYNTH
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("job popped from empty queue");
    a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == B_RUN) |-> (pos_reg < len_reg))
        else $error("character position past message length");
    a_prime_read: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == B_PRIME) && $past(st_reg == B_IDLE) |-> $past(rd_en))
        else $error("prime state without first text read");
`endif

endmodule

// ----- verif/tlmq_checker.sv -----
// Checker for the timed LCD message queue: predicts LCD entries and compares them.
`timescale 1ns / 1ps
module tlmq_checker
    import tlmq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [2:0] command,
    input  logic       screen_sel,
    input  logic [7:0] char_byte,
    input  logic       end_of_message,
    input  logic [7:0] timeout,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       lcd_screen,
    input  logic       entry_kind,
    input  logic [7:0] cursor_command,
    input  logic [7:0] char_code,
    input  logic       drop_event,
    input  logic       last_of_run,
    output int         errors,
    output int         pending,
    output int         entries_seen
);

    localparam int SLOTS        = 4;
    localparam int SLOT_BYTES   = 33;
    localparam int DISCARD_MARK = 63;

    typedef struct packed {
        logic       scr;
        logic       kind;
        logic [7:0] cmd;
        logic [7:0] ch;
        logic       drop;
        logic       last;
    } lcd_entry_t;

    lcd_entry_t lcd_q[$];
    int         step_n;

    logic [7:0] text[SCREENS][SLOTS][SLOT_BYTES];
    logic       occ[SCREENS][SLOTS];
    logic [7:0] dur[SCREENS][SLOTS];
    logic       qen[SCREENS];
    logic       lock[SCREENS];
    int         wr_slot[SCREENS];
    int         rd_slot[SCREENS];
    int         shown[SCREENS];
    int         msg_cnt[SCREENS];
    phase_t     ph[SCREENS];
    logic [7:0] hold_t[SCREENS];
    int         fpos[SCREENS];
    logic       factive[SCREENS];
    logic       cur_scr;

    task automatic push_entry(input logic s, input logic k, input logic [7:0] c,
                              input logic [7:0] h, input logic d);
        lcd_entry_t e;
        e = '{scr: s, kind: k, cmd: c, ch: h, drop: d, last: 1'b0};
        lcd_q.push_back(e);
        step_n++;
    endtask

    task automatic flush_screen(input int s);
        for (int i = 0; i < SLOTS; i++)
        begin
            occ[s][i] = 1'b0;
            dur[s][i] = '0;
        end
        rd_slot[s] = SLOTS - 1;
        wr_slot[s] = SLOTS - 1;
        msg_cnt[s] = 0;
        if (factive[s])
            fpos[s] = DISCARD_MARK;
        if (!lock[s])
            push_entry(s, 1'b0, LCD_CLEAR, 8'h00, 1'b0);
    endtask

    task automatic take_char(input int s, input bit is_err, input logic [7:0] ch,
                             input bit eom, input logic [7:0] to);
        int  probe;
        bit  found;
        int  w;
        int  p;
        if (!factive[s])
        begin
            found = 0;
            if (is_err)
            begin
                flush_screen(s);
                qen[s]  = 1'b1;
                lock[s] = 1'b1;
                ph[s]   = PH_WAIT;
            end
            probe = wr_slot[s];
            for (int k = 0; k < SLOTS && !found; k++)
            begin
                probe = (probe + 1) % SLOTS;
                if (!occ[s][probe])
                    found = 1;
            end
            factive[s] = 1'b1;
            if (found)
            begin
                wr_slot[s]     = probe;
                dur[s][probe]  = to;
                fpos[s]        = 0;
            end
            else
                fpos[s] = DISCARD_MARK;
        end
        if (fpos[s] != DISCARD_MARK)
        begin
            w = wr_slot[s];
            if (fpos[s] < SLOT_BYTES - 1)
            begin
                text[s][w][fpos[s]] = ch;
                fpos[s]++;
            end
            if (eom)
            begin
                p = (fpos[s] < SLOT_BYTES) ? fpos[s] : SLOT_BYTES - 1;
                text[s][w][p] = 8'h00;
                occ[s][w]     = 1'b1;
                msg_cnt[s]++;
            end
        end
        if (eom)
        begin
            factive[s] = 1'b0;
            fpos[s]    = 0;
        end
    endtask

    task automatic read_msg(input int s);
        int         probe;
        int         k;
        logic [7:0] c;
        logic [7:0] cc;
        probe = rd_slot[s];
        for (k = 0; k < SLOTS; k++)
        begin
            probe = (probe + 1) % SLOTS;
            if (occ[s][probe])
                break;
        end
        if (k == SLOTS)
            return;
        rd_slot[s] = probe;
        push_entry(s, 1'b0, LCD_CLEAR, 8'h00, 1'b0);
        for (int col = 1; col < SLOT_BYTES; col++)
        begin
            c = text[s][probe][col - 1];
            if (c == 8'h00)
                break;
            cc = (col < ROW_SPLIT) ? CURSOR_ROW0 + 8'(col) - 8'd1
                                   : CURSOR_ROW1 + 8'(col) - ROW1_OFFSET;
            push_entry(s, 1'b1, cc, c, 1'b0);
        end
        shown[s] = probe;
    endtask

    task automatic tick_step();
        int s;
        int d;
        int r;
        cur_scr = ~cur_scr;
        s = cur_scr;
        if (!qen[s])
            return;
        d = shown[s];
        case (ph[s])
            PH_WAIT: if (msg_cnt[s] != 0) ph[s] = PH_READ;
            PH_READ: ph[s] = PH_HOLD;
            PH_HOLD:
            begin
                if (occ[s][d] && dur[s][d] == 8'd0)
                    return;
                if (msg_cnt[s] == 0)
                    ph[s] = PH_WAIT;
                else if (dur[s][d] <= hold_t[s])
                    ph[s] = PH_DROP;
                hold_t[s] = hold_t[s] + 8'd1;
            end
            default: ph[s] = (msg_cnt[s] == 0) ? PH_WAIT : PH_READ;
        endcase
        if (ph[s] == PH_READ)
            read_msg(s);
        else if (ph[s] == PH_DROP)
        begin
            r = rd_slot[s];
            if (lock[s])
            begin
                lock[s] = 1'b0;
                qen[s]  = 1'b0;
                ph[s]   = PH_WAIT;
            end
            if (occ[s][r])
            begin
                occ[s][r] = 1'b0;
                msg_cnt[s]--;
            end
            dur[s][d] = '0;
            push_entry(s, 1'b0, LCD_CLEAR, 8'h00, 1'b1);
            hold_t[s] = HOLD_START;
        end
    endtask

    task automatic predict_item(input logic [2:0] cmd, input logic sel,
                                input logic [7:0] ch, input logic eom,
                                input logic [7:0] to);
        step_n = 0;
        case (cmd)
            CMD_TICK:  tick_step();
            CMD_WRITE: take_char(sel, 0, ch, eom, to);
            CMD_ERROR: take_char(sel, 1, ch, eom, to);
            CMD_CLEAR: flush_screen(sel);
            CMD_ON:    qen[sel] = 1'b1;
            CMD_OFF:
            begin
                lock[sel] = 1'b0;
                flush_screen(sel);
                qen[sel] = 1'b0;
            end
            default: ;
        endcase
        if (step_n > 0)
            lcd_q[lcd_q.size() - 1].last = 1'b1;
    endtask

    initial
    begin
        errors       = 0;
        entries_seen = 0;
        cur_scr      = 1'b0;
        for (int s = 0; s < SCREENS; s++)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                occ[s][i] = 1'b0;
                dur[s][i] = '0;
            end
            qen[s]     = 1'b1;
            lock[s]    = 1'b0;
            wr_slot[s] = SLOTS - 1;
            rd_slot[s] = SLOTS - 1;
            shown[s]   = 0;
            msg_cnt[s] = 0;
            ph[s]      = PH_WAIT;
            hold_t[s]  = HOLD_START;
            fpos[s]    = 0;
            factive[s] = 1'b0;
        end
    end

    assign pending = lcd_q.size();

    always @(posedge clk)
    begin
        lcd_entry_t got;
        lcd_entry_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{scr: lcd_screen, kind: entry_kind, cmd: cursor_command,
                        ch: char_code, drop: drop_event, last: last_of_run};
                entries_seen++;
                if (lcd_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected entry %h", got);
                end
                else
                begin
                    want = lcd_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("ERROR: entry %0d exp scr=%b kind=%b cmd=%h ch=%h drop=%b last=%b, got scr=%b kind=%b cmd=%h ch=%h drop=%b last=%b",
                                     entries_seen, want.scr, want.kind, want.cmd, want.ch,
                                     want.drop, want.last, got.scr, got.kind, got.cmd,
                                     got.ch, got.drop, got.last);
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_item(command, screen_sel, char_byte, end_of_message, timeout);
        end
    end

endmodule

// ----- verif/tb_top.sv -----
// Top of the timed LCD message queue testbench: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_top;
    import tlmq_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] command;
    logic       screen_sel;
    logic [7:0] char_byte;
    logic       end_of_message;
    logic [7:0] timeout;
    logic       out_valid;
    logic       out_stall;
    logic       lcd_screen;
    logic       entry_kind;
    logic [7:0] cursor_command;
    logic [7:0] char_code;
    logic       drop_event;
    logic       last_of_run;

    int errors;
    int pending;
    int entries_seen;
    int items_sent;
    int idle_cycles;
    bit in_quiet;
    bit out_quiet;

    timed_lcd_message_queue u_dut (.*);

    tlmq_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_item(input cmd_t cmd, input logic sel, input logic [7:0] ch,
                             input logic eom, input logic [7:0] to);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        command        <= cmd;
        screen_sel     <= sel;
        char_byte      <= ch;
        end_of_message <= eom;
        timeout        <= to;
        forever
        begin
            @(negedge clk);
            if (!in_stall)
                break;
        end
        @(posedge clk);
        items_sent++;
    endtask

    task automatic send_msg(input logic sel, input bit is_err, input int len,
                            input logic [7:0] to);
        for (int i = 0; i < len; i++)
            send_item((is_err && i == 0) ? CMD_ERROR : CMD_WRITE, sel,
                      8'($urandom_range(1, 255)), i == len - 1, to);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int w;
        out_stall = 1'b0;
        out_quiet = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (entries_seen % 50 == 0)
                out_quiet = ($urandom_range(0, 3) == 0);
            w = out_quiet ? 0 : $urandom_range(0, 8);
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            forever
            begin
                @(negedge clk);
                if (out_valid)
                    break;
            end
            @(posedge clk);
        end
    end

    initial
    begin
        int r;
        int len;
        logic [7:0] to;
        in_valid       = 1'b0;
        command        = CMD_TICK;
        screen_sel     = 1'b0;
        char_byte      = 8'h00;
        end_of_message = 1'b0;
        timeout        = 8'h00;
        items_sent     = 0;
        idle_cycles    = 0;
        in_quiet       = 1'b0;
        rst_n          = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: short and long messages, forever hold, reads and drops
        send_msg(1'b0, 0, 3, 8'd2);
        send_item(CMD_WRITE, 1'b1, 8'hFF, 1'b0, 8'd0);
        send_msg(1'b1, 0, 39, 8'd0);
        repeat (8) send_item(CMD_TICK, 1'b0, 8'h00, 1'b0, 8'd0);
        // zero character inside a message, command change after first char
        send_item(CMD_WRITE, 1'b0, 8'h41, 1'b0, 8'hFF);
        send_item(CMD_ERROR, 1'b0, 8'h00, 1'b0, 8'hFF);
        send_item(CMD_WRITE, 1'b0, 8'h42, 1'b1, 8'hFF);
        // fill the queue past four slots
        repeat (5) send_msg(1'b0, 0, 1, 8'd1);
        // clear during fill
        send_item(CMD_WRITE, 1'b1, 8'h55, 1'b0, 8'd3);
        send_item(CMD_CLEAR, 1'b1, 8'h00, 1'b0, 8'd0);
        send_item(CMD_WRITE, 1'b1, 8'hAA, 1'b1, 8'd3);
        send_msg(1'b1, 1, 2, 8'd1);
        send_item(CMD_CLEAR, 1'b1, 8'h00, 1'b0, 8'd0);
        send_item(CMD_OFF, 1'b0, 8'h00, 1'b0, 8'd0);
        send_item(cmd_t'(3'd6), 1'b0, 8'h00, 1'b0, 8'd0);
        send_item(cmd_t'(3'd7), 1'b1, 8'hFF, 1'b1, 8'hFF);
        repeat (6) send_item(CMD_TICK, 1'b1, 8'h00, 1'b0, 8'd0);
        send_item(CMD_ON, 1'b0, 8'h00, 1'b0, 8'd0);
        drain();
        send_item(CMD_OFF, 1'b1, 8'h00, 1'b0, 8'd0);
        send_item(CMD_ON, 1'b1, 8'h00, 1'b0, 8'd0);

        while (items_sent < 480)
        begin
            if (items_sent % 40 == 0)
                in_quiet = ($urandom_range(0, 3) == 0);
            if (items_sent % 120 == 119)
                drain();
            r = $urandom_range(0, 99);
            if (r < 45)
                send_item(CMD_TICK, 1'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
            else if (r < 80)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                                  : $urandom_range(1, 8);
                r = $urandom_range(0, 19);
                to = (r < 2) ? 8'd0 : (r == 2) ? 8'($urandom) : 8'($urandom_range(1, 6));
                send_msg(1'($urandom), $urandom_range(0, 9) == 0, len, to);
            end
            else if (r < 85)
                send_item(CMD_CLEAR, 1'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
            else if (r < 91)
                send_item(CMD_ON, 1'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
            else if (r < 93)
                send_item(CMD_OFF, 1'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
            else if (r < 97)
                send_item($urandom_range(0, 1) ? CMD_WRITE : CMD_ERROR, 1'($urandom),
                          8'($urandom), 1'b0, 8'($urandom));
            else
            begin
                send_item(cmd_t'(3'($urandom_range(6, 7))), 1'($urandom), 8'($urandom),
                          1'($urandom), 8'($urandom));
                items_sent--;
            end
        end

        drain();
        repeat (100) @(posedge clk);
        $display("Run covered %0d input items and %0d LCD entries on both screens.",
                 items_sent, entries_seen);
        $display("Mismatches: %0d", errors);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
